// File: hw/rtl/pfsbt_pkg.sv
// ---------------------------------------------------------------------------
// pfsbt_pkg
// Shared types and constants of the per-file sync batch trigger.
// ---------------------------------------------------------------------------
package pfsbt_pkg;

   localparam int SLOTS  = 16;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int FILE_W  = 16;
   localparam int COUNT_W = 16;
   localparam int TIME_W  = 32;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Request function codes.
   localparam logic [1:0] FUNC_WRITE     = 2'd0;
   localparam logic [1:0] FUNC_FLUSH_ONE = 2'd1;
   localparam logic [1:0] FUNC_FLUSH_ALL = 2'd2;
   localparam logic [1:0] FUNC_TICK      = 2'd3;

   // Durability modes.
   localparam logic [1:0] DUR_NONE      = 2'd0;
   localparam logic [1:0] DUR_BATCHED   = 2'd1;
   localparam logic [1:0] DUR_IMMEDIATE = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_WIN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DUR_MODE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_ONLY   = 2'd3;

   // Register reset values.
   localparam logic [15:0] RST_BATCH_SIZE = 16'd64;
   localparam logic [15:0] RST_BATCH_WIN  = 16'd10;
   localparam logic [1:0]  RST_DUR_MODE   = DUR_BATCHED;
   localparam logic        RST_DATA_ONLY  = 1'b1;

   typedef struct packed {
      logic load;
      logic tick;
      logic lookup;
      logic update;
      logic sweep_clear;
      logic sweep_emit;
      logic sweep_inc;
      logic close;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic sweep_hit;
      logic sweep_end;
   } sts_type;

endpackage

// File: hw/rtl/pfsbt_ifs.sv
// ---------------------------------------------------------------------------
// pfsbt request and response channels
// Valid/ready channels carrying a request and a response item.
// ---------------------------------------------------------------------------
interface pfsbt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] file_id;

   modport source (output valid, output func, output file_id, input ready);
   modport sink   (input valid, input func, input file_id, output ready);
endinterface

interface pfsbt_rsp_if;
   logic        valid;
   logic        ready;
   logic        sync_issue;
   logic [15:0] sync_file;
   logic        sync_kind;
   logic [15:0] cleared_count;
   logic        no_slot;
   logic        last;

   modport source (output valid, output sync_issue, output sync_file, output sync_kind,
                   output cleared_count, output no_slot, output last, input ready);
   modport sink   (input valid, input sync_issue, input sync_file, input sync_kind,
                   input cleared_count, input no_slot, input last, output ready);
endinterface

// File: hw/rtl/pfsbt_ctrl.sv
// ---------------------------------------------------------------------------
// pfsbt_ctrl
// Sequencer: accepts a request and handles a tick at once, steps other requests
// through lookup and update, or walks the slot table for a flush of all files.
// ---------------------------------------------------------------------------
module pfsbt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_func,
   output logic                  req_ready,
   output pfsbt_pkg::cmd_type    cmd,
   input  pfsbt_pkg::sts_type    sts
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_LOOK  = 5'b00010,
      S_UPD   = 5'b00100,
      S_SWEEP = 5'b01000,
      S_CLOSE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_func == pfsbt_pkg::FUNC_TICK) begin
                  cmd.tick = 1'b1;
               end else if (req_func == pfsbt_pkg::FUNC_FLUSH_ALL) begin
                  cmd.sweep_clear = 1'b1;
                  state_in = S_SWEEP;
               end else begin
                  state_in = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            cmd.lookup = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            if (sts.out_free) begin
               cmd.update = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SWEEP: begin
            // A slot with nothing pending is skipped without waiting on the output.
            if (!sts.sweep_hit || sts.out_free) begin
               cmd.sweep_emit = sts.sweep_hit;
               if (sts.sweep_end) begin
                  state_in = S_CLOSE;
               end else begin
                  cmd.sweep_inc = 1'b1;
               end
            end
         end
         S_CLOSE: begin
            if (sts.out_free) begin
               cmd.close = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/pfsbt_dp.sv
// ---------------------------------------------------------------------------
// pfsbt_dp
// Datapath: configuration registers, slot table, millisecond clock and the
// response register.
// ---------------------------------------------------------------------------
module pfsbt_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [1:0]                          req_func,
   input  logic [pfsbt_pkg::FILE_W-1:0]        req_file_id,
   input  logic                                csr_we,
   input  logic [pfsbt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pfsbt_pkg::CSR_W-1:0]         csr_wdata,
   input  pfsbt_pkg::cmd_type                  cmd,
   output pfsbt_pkg::sts_type                  sts,
   pfsbt_rsp_if.source                         rsp
);

   localparam int SLOTS   = pfsbt_pkg::SLOTS;
   localparam int SLOT_W  = pfsbt_pkg::SLOT_W;
   localparam int FILE_W  = pfsbt_pkg::FILE_W;
   localparam int COUNT_W = pfsbt_pkg::COUNT_W;
   localparam int TIME_W  = pfsbt_pkg::TIME_W;

   // Configuration.
   logic [15:0] batch_size_ff;
   logic [15:0] batch_win_ff;
   logic [1:0]  dur_mode_ff;
   logic        data_only_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_size_ff <= pfsbt_pkg::RST_BATCH_SIZE;
         batch_win_ff  <= pfsbt_pkg::RST_BATCH_WIN;
         dur_mode_ff   <= pfsbt_pkg::RST_DUR_MODE;
         data_only_ff  <= pfsbt_pkg::RST_DATA_ONLY;
      end else if (csr_we) begin
         unique case (csr_index)
            pfsbt_pkg::CSR_BATCH_SIZE: batch_size_ff <= csr_wdata[15:0];
            pfsbt_pkg::CSR_BATCH_WIN:  batch_win_ff  <= csr_wdata[15:0];
            pfsbt_pkg::CSR_DUR_MODE:   dur_mode_ff   <= csr_wdata[1:0];
            pfsbt_pkg::CSR_DATA_ONLY:  data_only_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Latched request and time.
   logic [1:0]        func_ff;
   logic [FILE_W-1:0] file_ff;
   logic [TIME_W-1:0] now_ms_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         file_ff <= req_file_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ms_ff <= '0;
      end else if (cmd.tick) begin
         now_ms_ff <= now_ms_ff + TIME_W'(1);
      end
   end

   // Slot table.
   logic [SLOTS-1:0]   slot_valid_ff;
   logic [FILE_W-1:0]  slot_file_ff     [SLOTS];
   logic [COUNT_W-1:0] slot_pending_ff  [SLOTS];
   logic [TIME_W-1:0]  slot_last_ff     [SLOTS];

   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic               full_ff, full_in;

   // Parallel tag match and lowest free slot.
   logic [SLOT_W-1:0]  hit_idx, free_idx;
   logic               hit_any, free_any;

   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      hit_any  = 1'b0;
      free_any = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (slot_valid_ff[i] && (slot_file_ff[i] == file_ff)) begin
            hit_idx = SLOT_W'(i);
            hit_any = 1'b1;
         end
         if (!slot_valid_ff[i]) begin
            free_idx = SLOT_W'(i);
            free_any = 1'b1;
         end
      end
   end

   logic alloc;
   assign alloc = cmd.lookup && !hit_any && free_any;

   always_comb begin
      idx_in  = idx_ff;
      full_in = full_ff;
      if (cmd.lookup) begin
         idx_in  = hit_any ? hit_idx : free_idx;
         full_in = !hit_any && !free_any;
      end else if (cmd.sweep_clear) begin
         idx_in = '0;
      end else if (cmd.sweep_inc) begin
         idx_in = idx_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      full_ff <= full_in;
   end

   // Entry at the current index.
   logic [COUNT_W-1:0] cur_pending;
   logic [TIME_W-1:0]  cur_last;
   logic [FILE_W-1:0]  cur_file;
   assign cur_pending = slot_pending_ff[idx_ff];
   assign cur_last    = slot_last_ff[idx_ff];
   assign cur_file    = slot_file_ff[idx_ff];

   logic               can_sync;
   logic [COUNT_W-1:0] pend_inc;
   logic [TIME_W-1:0]  elapsed;
   logic               fire;

   assign can_sync = (dur_mode_ff != pfsbt_pkg::DUR_NONE);
   assign pend_inc = (cur_pending == pfsbt_pkg::COUNT_MAX) ? cur_pending
                                                           : cur_pending + COUNT_W'(1);
   assign elapsed  = now_ms_ff - cur_last;

   always_comb begin
      case (dur_mode_ff)
         pfsbt_pkg::DUR_IMMEDIATE: fire = 1'b1;
         pfsbt_pkg::DUR_NONE:      fire = 1'b0;
         default: fire = (pend_inc >= batch_size_ff) ||
                         (elapsed >= {{(TIME_W-16){1'b0}}, batch_win_ff});
      endcase
   end

   // Slot writes and response assembly.
   logic               pend_we, last_we;
   logic [COUNT_W-1:0] pend_wdata;
   logic               out_load;
   logic               out_issue_in, out_noslot_in, out_last_in;
   logic [FILE_W-1:0]  out_file_in;
   logic [COUNT_W-1:0] out_count_in;
   logic               is_write;

   assign is_write = (func_ff == pfsbt_pkg::FUNC_WRITE);

   always_comb begin
      pend_we       = 1'b0;
      last_we       = 1'b0;
      pend_wdata    = '0;
      out_load      = 1'b0;
      out_issue_in  = 1'b0;
      out_file_in   = file_ff;
      out_count_in  = '0;
      out_noslot_in = 1'b0;
      out_last_in   = 1'b1;
      if (cmd.update) begin
         out_load = 1'b1;
         if (full_ff) begin
            out_noslot_in = 1'b1;
            out_issue_in  = is_write && can_sync;
         end else if (is_write) begin
            pend_we = 1'b1;
            if (fire) begin
               // The incremented count is never zero, so a fire always clears.
               pend_wdata   = '0;
               last_we      = 1'b1;
               out_issue_in = can_sync;
               out_count_in = pend_inc;
            end else begin
               pend_wdata = pend_inc;
            end
         end else begin
            out_count_in = cur_pending;
            if (cur_pending != '0) begin
               pend_we      = 1'b1;
               last_we      = 1'b1;
               out_issue_in = can_sync;
            end
         end
      end else if (cmd.sweep_emit) begin
         out_load     = 1'b1;
         pend_we      = 1'b1;
         last_we      = 1'b1;
         out_issue_in = can_sync;
         out_file_in  = cur_file;
         out_count_in = cur_pending;
         out_last_in  = 1'b0;
      end else if (cmd.close) begin
         out_load    = 1'b1;
         out_file_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (alloc) begin
         slot_valid_ff[free_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (alloc) begin
         slot_file_ff[free_idx]    <= file_ff;
         slot_pending_ff[free_idx] <= '0;
         slot_last_ff[free_idx]    <= now_ms_ff;
      end
      if (pend_we) begin
         slot_pending_ff[idx_ff] <= pend_wdata;
      end
      if (last_we) begin
         slot_last_ff[idx_ff] <= now_ms_ff;
      end
   end

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_issue_ff, rsp_kind_ff, rsp_noslot_ff, rsp_last_ff;
   logic [FILE_W-1:0]  rsp_file_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_issue_ff  <= out_issue_in;
         rsp_file_ff   <= out_file_in;
         rsp_kind_ff   <= data_only_ff;
         rsp_count_ff  <= out_count_in;
         rsp_noslot_ff <= out_noslot_in;
         rsp_last_ff   <= out_last_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.sync_issue    = rsp_issue_ff;
   assign rsp.sync_file     = rsp_file_ff;
   assign rsp.sync_kind     = rsp_kind_ff;
   assign rsp.cleared_count = rsp_count_ff;
   assign rsp.no_slot       = rsp_noslot_ff;
   assign rsp.last          = rsp_last_ff;

   assign sts.out_free  = !rsp_valid_ff || rsp.ready;
   assign sts.sweep_hit = slot_valid_ff[idx_ff] && (cur_pending != '0);
   assign sts.sweep_end = (idx_ff == SLOT_W'(SLOTS - 1));

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_load && rsp_valid_ff) |-> rsp.ready)
      else $error("response overwritten before it was taken");

   a_noslot_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_noslot_ff) |-> (rsp_count_ff == '0))
      else $error("untracked file reported a flushed count");

   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      cmd.tick |=> (now_ms_ff == $past(now_ms_ff) + TIME_W'(1)))
      else $error("millisecond clock did not advance on a tick");

   a_valid_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((slot_valid_ff & $past(slot_valid_ff)) == $past(slot_valid_ff)))
      else $error("a slot was released");
`endif

endmodule

// File: hw/rtl/per_file_sync_batch_trigger.sv
// ---------------------------------------------------------------------------
// per_file_sync_batch_trigger
// Group-commit trigger: tracks pending writes per file and issues syncs on
// count, time window, mode or explicit flush.
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    func, file_id
//   rsp_ch   out  valid/ready    sync_issue, sync_file, sync_kind,
//                                cleared_count, no_slot, last
//   csr      in   csr_we         csr_index, csr_wdata
//
// A tick is handled when it is accepted. A write or flush of one file steps
// through accept, a parallel tag match over the slot table, then the slot
// update. A flush of all files walks the slot table one entry per cycle,
// waiting on the response register only at entries with pending writes.
// Reset is synchronous; the slot table needs no clearing pass. A result
// waits in the response register while a new request is accepted; a stalled
// response holds the sequencer only when it has the next result to deliver.
// ---------------------------------------------------------------------------
module per_file_sync_batch_trigger (
   input  logic                                clock,
   input  logic                                reset,
   pfsbt_req_if.sink                           req_ch,
   pfsbt_rsp_if.source                         rsp_ch,
   input  logic                                csr_we,
   input  logic [pfsbt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pfsbt_pkg::CSR_W-1:0]         csr_wdata
);

   pfsbt_pkg::cmd_type cmd;
   pfsbt_pkg::sts_type sts;

   pfsbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   pfsbt_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_func    (req_ch.func),
      .req_file_id (req_ch.file_id),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .sts         (sts),
      .rsp         (rsp_ch)
   );

endmodule
